FILE: src/mmfrs_pkg.sv
`timescale 1ns / 1ps
package mmfrs_pkg;

    // Series limits
    localparam int unsigned MAX_WINDOW = 16;
    localparam int unsigned MAX_LENGTH = 65536;

    // Field and state widths
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned LEN_W    = 5;
    localparam int unsigned RING_AW  = $clog2(MAX_WINDOW);
    localparam int unsigned SEEN_W   = $clog2(MAX_LENGTH) + 1;
    localparam int unsigned WSUM_W   = SAMPLE_W + RING_AW;
    localparam int unsigned ERR_W    = WSUM_W + 2;
    localparam int unsigned RSUM_W   = 40;
    localparam int unsigned SQ_W     = 60;
    localparam int unsigned NUM_W    = 2 * RSUM_W;
    localparam int unsigned DEN_W    = 2 * LEN_W + 2 * SEEN_W;
    localparam int unsigned REM_W    = DEN_W + 1;
    localparam int unsigned Q_W      = 32;
    localparam int unsigned ROOT_W   = 16;
    localparam int unsigned CNT_W    = 7;

    // Reset value of the window length register
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(3);

endpackage

FILE: src/mmfrs_in_if.sv
`timescale 1ns / 1ps
interface mmfrs_in_if
    import mmfrs_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

FILE: src/mmfrs_out_if.sv
`timescale 1ns / 1ps
interface mmfrs_out_if
    import mmfrs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ROOT_W-1:0]   std_error;
    logic                valid_res;

    modport source (output valid, output std_error, output valid_res, input ready);
    modport sink   (input valid, input std_error, input valid_res, output ready);
endinterface

FILE: src/moving_mean_forecast_residual_stddev_top.sv
`timescale 1ns / 1ps
// Channel | Dir | Payload                         | Handshake
// series  | in  | sample[15:0] signed, last       | valid/ready
// result  | out | std_error[15:0], valid_res      | valid/ready
// cfg     | in  | cfg_wdata[4:0] (window length)  | cfg_we, no wait
//
// A sample request passes from acceptance to the next ready through the
// accepting cycle, ring read, window update and write-back, then square and
// accumulate; the ring RAM's registered read sets the first two.
// A last sample then runs prep, serial multiplies over 17 bits of n and 40
// of |sum|, two denominator states, an 80-step restoring divide, a 16-step
// root and an output state before ready returns, more while the result is still held.
// Reset clears all control and accumulators; the ring RAM is not cleared.
// A pending result stalls only the finish of the next series.
module moving_mean_forecast_residual_stddev_top
    import mmfrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LEN_W-1:0]   cfg_wdata,
    mmfrs_in_if.sink           series,
    mmfrs_out_if.source        result
);
    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_UPD, S_ACC, S_PREP, S_MULA, S_MULB,
        S_DEN1, S_DEN2, S_DIV, S_SQRT, S_OUT
    } state_t;

    state_t                      state_reg;
    logic [LEN_W-1:0]            wlen_reg;
    logic [LEN_W-1:0]            len_reg;
    logic [RING_AW-1:0]          pos_reg;
    logic signed [WSUM_W-1:0]    wsum_reg;
    logic [SEEN_W-1:0]           seen_reg;
    logic signed [RSUM_W-1:0]    rsum_reg;
    logic [SQ_W-1:0]             sq_reg;
    logic signed [SAMPLE_W-1:0]  y_reg;
    logic                        last_reg;
    logic signed [ERR_W-1:0]     e_reg;
    logic                        res_reg;
    logic [SEEN_W-1:0]           n_reg;
    logic [RSUM_W-1:0]           mag_reg;
    logic [RSUM_W-1:0]           msh_reg;
    logic [NUM_W-1:0]            num_reg;
    logic [NUM_W-1:0]            acc_reg;
    logic [DEN_W-1:0]            den_reg;
    logic [REM_W-1:0]            rem_reg;
    logic [Q_W-1:0]              q_reg;
    logic                        sat_reg;
    logic [ROOT_W-1:0]           root_reg;
    logic [ROOT_W-1:0]           bit_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [ROOT_W-1:0]           sd_reg;
    logic                        ok_reg;
    logic                        out_valid_reg;
    logic [ROOT_W-1:0]           out_sd_reg;
    logic                        out_ok_reg;

    logic                        in_acc;
    logic [LEN_W-1:0]            len_clamp;
    logic [LEN_W-1:0]            len_eff;
    logic                        ram_we;
    logic [RING_AW-1:0]          ram_raddr;
    logic [SAMPLE_W-1:0]         ram_rdata;
    logic                        active;
    logic signed [ERR_W-1:0]     ly;
    logic signed [ERR_W-1:0]     e_next;
    logic signed [2*ERR_W-1:0]   e_sq;
    logic [SEEN_W-1:0]           n_next;
    logic [2*SEEN_W-1:0]         n_pair;
    logic [2*LEN_W-1:0]          len_sq;
    logic [DEN_W-1:0]            den_scaled;
    logic [REM_W-1:0]            rem_shift;
    logic [Q_W:0]                q_shift;
    logic [ROOT_W-1:0]           root_try;
    logic [2*ROOT_W-1:0]         root_sq;

    // Window length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= LEN_RESET;
        end
        else if (cfg_we)
        begin
            wlen_reg <= cfg_wdata;
        end
    end

    // Clamp to 1..MAX_WINDOW, latched on the first sample of a series
    always_comb
    begin
        if (wlen_reg == '0)
            len_clamp = LEN_W'(1);
        else if (wlen_reg > LEN_W'(MAX_WINDOW))
            len_clamp = LEN_W'(MAX_WINDOW);
        else
            len_clamp = wlen_reg;
        len_eff = (seen_reg == '0) ? len_clamp : len_reg;
    end

    assign in_acc       = series.valid && series.ready;
    assign series.ready = (state_reg == S_IDLE);
    assign active       = (seen_reg < SEEN_W'(MAX_LENGTH));
    assign ram_we       = (state_reg == S_UPD) && active;
    assign ram_raddr    = pos_reg - len_eff[RING_AW-1:0];

    // Residual: L*y minus the window sum, and its exact square
    assign ly     = ERR_W'($signed({1'b0, len_reg})) * ERR_W'(y_reg);
    assign e_next = ly - ERR_W'(wsum_reg);
    assign e_sq   = e_reg * e_reg;

    assign n_next = (seen_reg > SEEN_W'(len_reg)) ? seen_reg - SEEN_W'(len_reg) : '0;

    // Denominator factors: n*(n-1), then times L*L
    assign n_pair     = n_reg * (n_reg - SEEN_W'(1));
    assign len_sq     = len_reg * len_reg;
    assign den_scaled = den_reg[2*SEEN_W-1:0] * len_sq;

    // Divider and root step
    assign rem_shift = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
    assign root_try  = root_reg | bit_reg;
    assign root_sq   = root_try * root_try;
    always_comb
    begin
        q_shift = {q_reg, 1'b0};
        if (rem_shift >= REM_W'(den_reg))
            q_shift[0] = 1'b1;
    end

    mmfrs_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (y_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer, accumulators and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= LEN_W'(1);
            pos_reg       <= '0;
            wsum_reg      <= '0;
            seen_reg      <= '0;
            rsum_reg      <= '0;
            sq_reg        <= '0;
            y_reg         <= '0;
            last_reg      <= 1'b0;
            e_reg         <= '0;
            res_reg       <= 1'b0;
            n_reg         <= '0;
            mag_reg       <= '0;
            msh_reg       <= '0;
            num_reg       <= '0;
            acc_reg       <= '0;
            den_reg       <= '0;
            rem_reg       <= '0;
            q_reg         <= '0;
            sat_reg       <= 1'b0;
            root_reg      <= '0;
            bit_reg       <= '0;
            cnt_reg       <= '0;
            sd_reg        <= '0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_sd_reg    <= '0;
            out_ok_reg    <= 1'b0;
        end
        else
        begin
            // Output drains here unless a new result is loaded below
            if (out_valid_reg && result.ready && (state_reg != S_OUT))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        y_reg    <= series.sample;
                        last_reg <= series.last;
                        len_reg  <= len_eff;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    res_reg <= active && (seen_reg >= SEEN_W'(len_reg));
                    if (active)
                    begin
                        if (seen_reg >= SEEN_W'(len_reg))
                        begin
                            e_reg    <= e_next;
                            wsum_reg <= wsum_reg + WSUM_W'(y_reg)
                                        - WSUM_W'($signed(ram_rdata));
                        end
                        else
                        begin
                            wsum_reg <= wsum_reg + WSUM_W'(y_reg);
                        end
                        pos_reg  <= pos_reg + RING_AW'(1);
                        seen_reg <= seen_reg + SEEN_W'(1);
                    end
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (res_reg)
                    begin
                        rsum_reg <= rsum_reg + RSUM_W'(e_reg);
                        sq_reg   <= sq_reg + SQ_W'(unsigned'(e_sq));
                    end
                    state_reg <= last_reg ? S_PREP : S_IDLE;
                end
                S_PREP:
                begin
                    n_reg   <= n_next;
                    mag_reg <= rsum_reg[RSUM_W-1] ? RSUM_W'(-rsum_reg) : RSUM_W'(rsum_reg);
                    msh_reg <= {n_next, (RSUM_W - SEEN_W)'(0)};
                    num_reg <= '0;
                    acc_reg <= '0;
                    cnt_reg <= '0;
                    if (n_next < SEEN_W'(2))
                    begin
                        sd_reg    <= '0;
                        ok_reg    <= 1'b0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_MULA;
                    end
                end
                S_MULA:
                begin
                    // n * sum(e^2), one bit of n a cycle
                    num_reg <= (num_reg << 1)
                               + (msh_reg[RSUM_W-1] ? NUM_W'(sq_reg) : '0);
                    if (cnt_reg == CNT_W'(SEEN_W - 1))
                    begin
                        cnt_reg   <= '0;
                        msh_reg   <= mag_reg;
                        state_reg <= S_MULB;
                    end
                    else
                    begin
                        msh_reg <= msh_reg << 1;
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                S_MULB:
                begin
                    // sum(e)^2, one bit of |sum| a cycle
                    acc_reg <= (acc_reg << 1)
                               + (msh_reg[RSUM_W-1] ? NUM_W'(mag_reg) : '0);
                    msh_reg <= msh_reg << 1;
                    if (cnt_reg == CNT_W'(RSUM_W - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_DEN1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                S_DEN1:
                begin
                    num_reg   <= num_reg - acc_reg;
                    den_reg   <= DEN_W'(n_pair);
                    state_reg <= S_DEN2;
                end
                S_DEN2:
                begin
                    den_reg   <= den_scaled;
                    rem_reg   <= '0;
                    q_reg     <= '0;
                    sat_reg   <= 1'b0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    // Restoring divide, quotient saturates above 32 bits
                    num_reg <= num_reg << 1;
                    if (rem_shift >= REM_W'(den_reg))
                        rem_reg <= rem_shift - REM_W'(den_reg);
                    else
                        rem_reg <= rem_shift;
                    q_reg   <= q_shift[Q_W-1:0];
                    if (q_shift[Q_W])
                        sat_reg <= 1'b1;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(NUM_W - 1))
                    begin
                        root_reg  <= '0;
                        bit_reg   <= {1'b1, (ROOT_W - 1)'(0)};
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    // Floor root, one bit a cycle
                    if (root_sq <= q_reg)
                        root_reg <= root_try;
                    bit_reg <= bit_reg >> 1;
                    if (bit_reg[0])
                    begin
                        sd_reg    <= sat_reg ? '1
                                     : ((root_sq <= q_reg) ? root_try : root_reg);
                        ok_reg    <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_sd_reg    <= sd_reg;
                        out_ok_reg    <= ok_reg;
                        pos_reg       <= '0;
                        wsum_reg      <= '0;
                        seen_reg      <= '0;
                        rsum_reg      <= '0;
                        sq_reg        <= '0;
                        len_reg       <= LEN_W'(1);
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.std_error = out_sd_reg;
    assign result.valid_res = out_ok_reg;

    // Checks
    a_zero_when_short: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.valid_res |-> result.std_error == '0)
        else $error("std_error not zero with too few residuals");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg != '0 && len_reg <= LEN_W'(MAX_WINDOW))
        else $error("latched window length out of range");

    a_ring_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> seen_reg < SEEN_W'(MAX_LENGTH) && state_reg == S_UPD)
        else $error("ring written outside update");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == S_READ)
        else $error("accepted request did not start a ring read");
endmodule

FILE: src/mmfrs_ram.sv
`timescale 1ns / 1ps
module mmfrs_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
